// ----- design/stuffed_frame_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define SFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stuffed frame receiver check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stuffed frame receiver check failed");

`endif

// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Shared widths, codes and types for the frame receiver and its parts.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Default limit on kept bytes (id plus body) in one frame.
  localparam int SFR_MAX_FRAME_BYTES = 256;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Reset values of the special characters.
  localparam logic [BYTE_W-1:0] START_CHAR_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] END_CHAR_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_CHAR_RST = 8'd27;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_ESCAPE = 2'd2
  } sfr_cfg_idx_t;

  // Receiver mode.
  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_FRAME = 2'd2
  } sfr_mode_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 3'd0,
    KIND_ID   = 3'd1,
    KIND_BODY = 3'd2,
    KIND_GOOD = 3'd3,
    KIND_CSUM = 3'd4,
    KIND_BAD  = 3'd5
  } sfr_kind_t;

  // The three special characters as held in configuration.
  typedef struct packed {
    logic [BYTE_W-1:0] start_char;
    logic [BYTE_W-1:0] end_char;
    logic [BYTE_W-1:0] escape_char;
  } sfr_chars_t;

  // One result as it travels from the decoder to the output buffer.
  typedef struct packed {
    sfr_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] plen;
  } sfr_result_t;

endpackage

// ----- design/sfr_if.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver channels
// Valid/ready interfaces for received bytes and for frame results.
// ----------------------------------------------------------------------------

// Received line bytes.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Frame results.
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] payload_length;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_index, output payload_length, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_index, input payload_length, output ready);
endinterface

// ----- design/sfr_decoder.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver decoder
// Per-byte frame state machine: unstuffing, counting, checksum and verdict.
// ----------------------------------------------------------------------------
module sfr_decoder import sfr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = SFR_MAX_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_chars_t        chars,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] rx_byte,
  output sfr_result_t       result
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  sfr_mode_t         mode_r,  mode_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] sum_r,   sum_nxt;
  logic              ovf_r,   ovf_nxt;

  logic              esc_open;
  logic              in_frame;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  count_m2;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      count_r <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign count_m1 = count_r - CNT_W'(1);
  assign count_m2 = count_r - CNT_W'(2);

  // Mode decode; the unused code behaves as hunting.
  always_comb begin
    unique case (mode_r)
      MODE_ESC: begin
        esc_open = 1'b1;
        in_frame = 1'b1;
      end
      MODE_FRAME: begin
        esc_open = 1'b0;
        in_frame = 1'b1;
      end
      default: begin
        esc_open = 1'b0;
        in_frame = 1'b0;
      end
    endcase
  end

  // Next state and result for one accepted byte.
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    ovf_nxt   = ovf_r;
    result    = '{kind: KIND_NONE, data: '0, index: '0, plen: '0};

    if (byte_fire) begin
      priority if (!esc_open && rx_byte == chars.start_char) begin
        // A start opens a fresh frame and silently drops any open one.
        mode_nxt  = MODE_FRAME;
        count_nxt = '0;
        sum_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (!esc_open && rx_byte == chars.end_char) begin
        // An end closes the frame and gives the verdict.
        if (in_frame) begin
          priority if (ovf_r || count_r < CNT_W'(2)) begin
            result.kind = KIND_BAD;
          end else if (sum_r == '0) begin
            result.kind = KIND_GOOD;
            result.plen = BYTE_W'(count_m2);
          end else begin
            result.kind = KIND_CSUM;
          end
        end
        mode_nxt  = MODE_HUNT;
        count_nxt = '0;
        sum_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (in_frame) begin
        // Every byte inside a frame, escapes included, enters the sum.
        sum_nxt = sum_r + rx_byte;
        if (mode_r == MODE_FRAME && rx_byte == chars.escape_char) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_FRAME;
          priority if (count_r == '0) begin
            result.kind = KIND_ID;
            result.data = rx_byte;
            count_nxt   = CNT_W'(1);
          end else if (count_r < CNT_W'(MAX_FRAME_BYTES)) begin
            result.kind  = KIND_BODY;
            result.data  = rx_byte;
            result.index = BYTE_W'(count_m1);
            count_nxt    = count_r + CNT_W'(1);
          end else begin
            // Frame is full: the byte is dropped and remembered.
            ovf_nxt = 1'b1;
          end
        end
      end else begin
        mode_nxt = MODE_HUNT;
      end
    end
  end

endmodule

// ----- design/sfr_out_buf.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver output buffer
// Result register with a skid stage, so a stalled sink does not stop intake
// until two results are waiting.
// ----------------------------------------------------------------------------
module sfr_out_buf import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sfr_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output sfr_result_t out_data
);

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  sfr_result_t main_r,       main_nxt;
  sfr_result_t skid_r,       skid_nxt;
  logic        pop;

  assign pop       = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // Refill the result register from the skid stage first, then from a new
  // request; park the new request in the skid stage when the sink stalls.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;

    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

endmodule

// ----- design/stuffed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver
// Finds byte-stuffed frames in a received byte stream and checks their
// additive checksum.
// ----------------------------------------------------------------------------
// The receiver takes one line byte per clock cycle while the result sink keeps
// up and gives exactly one registered result request for every byte it takes.
// The per-byte decode is a compare against the three special characters and an
// 8-bit add, done combinationally ahead of the result register, so the sustained
// rate is one byte per cycle whenever the result sink is ready. A two-entry output
// buffer (result register plus skid stage) lets intake go on for one more byte
// while a result waits; a result parked in the skid stage moves up when the one
// ahead of it leaves, and in_chan.ready falls only when both entries are full.
// The user is to write the special characters through the cfg_ port while the
// receiver is idle; the block itself does not enforce this. An index beyond the
// escape character is ignored.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver import sfr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = SFR_MAX_FRAME_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  sfr_in_if.sink               in_chan,
  sfr_out_if.source            out_chan
);

  sfr_chars_t  chars_r;
  sfr_result_t dec_result;
  sfr_result_t buf_data;
  logic        byte_fire;
  logic        can_push;

  // Special character registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r.start_char  <= START_CHAR_RST;
      chars_r.end_char    <= END_CHAR_RST;
      chars_r.escape_char <= ESCAPE_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:  chars_r.start_char  <= cfg_wdata;
        CFG_END:    chars_r.end_char    <= cfg_wdata;
        CFG_ESCAPE: chars_r.escape_char <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign in_chan.ready = can_push;
  assign byte_fire     = in_chan.valid && can_push;

  // Frame decoder.
  sfr_decoder #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .chars     (chars_r),
    .byte_fire (byte_fire),
    .rx_byte   (in_chan.rx_byte),
    .result    (dec_result)
  );

  // Result register and skid stage.
  sfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_fire),
    .push_data (dec_result),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (buf_data)
  );

  assign out_chan.result_kind    = buf_data.kind;
  assign out_chan.data_byte      = buf_data.data;
  assign out_chan.byte_index     = buf_data.index;
  assign out_chan.payload_length = buf_data.plen;

endmodule

// ----- design/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver checker
// Port-level assertions on the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "stuffed_frame_receiver_macros.svh"

module sfr_checker import sfr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] result_kind,
  input logic [BYTE_W-1:0] data_byte,
  input logic [BYTE_W-1:0] byte_index,
  input logic [BYTE_W-1:0] payload_length
);

  logic in_fire;
  logic has_data;

  assign in_fire  = in_valid && in_ready;
  assign has_data = (result_kind == KIND_ID) || (result_kind == KIND_BODY);

  // A stalled result keeps its payload.
  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(result_kind) && $stable(data_byte)
                   && $stable(byte_index) && $stable(payload_length))

  // A new result only ever follows an accepted byte.
  `SFR_ASSERT_IMPL(a_out_after_accept, $rose(out_valid), $past(in_fire))

  // Only endpoint id and body results carry a data byte.
  `SFR_ASSERT_IMPL(a_data_zero, out_valid && !has_data,
                   data_byte == '0 && byte_index == '0)

  // A payload length is only reported with a good frame.
  `SFR_ASSERT_IMPL(a_plen_good, out_valid && result_kind != KIND_GOOD,
                   payload_length == '0)

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .result_kind    (out_chan.result_kind),
  .data_byte      (out_chan.data_byte),
  .byte_index     (out_chan.byte_index),
  .payload_length (out_chan.payload_length)
);

// ----- tb/tb_stuffed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench
// Feeds byte-stuffed frames, broken frames and line noise to the receiver
// under several special-character settings. A software decoder of the same
// framing predicts one result for every byte taken, and each result leaving
// the block is compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  // Register index with no register behind it; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 200;

  // Decoder of the line framing, with its own copy of the characters and
  // frame state, and the results it expects in order.
  class frame_decoder_model;
    sfr_chars_t  chars;
    sfr_mode_t   mode;
    logic [8:0]  kept;
    logic [7:0]  sum;
    bit          ovf;
    sfr_result_t awaited_results[$];
    int          mismatches;

    function new();
      chars.start_char  = START_CHAR_RST;
      chars.end_char    = END_CHAR_RST;
      chars.escape_char = ESCAPE_CHAR_RST;
      mode              = MODE_HUNT;
      mismatches        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      kept = '0;
      sum  = '0;
      ovf  = 1'b0;
    endfunction

    function void write_char(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_START:  chars.start_char  = v;
        CFG_END:    chars.end_char    = v;
        CFG_ESCAPE: chars.escape_char = v;
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted line byte and queues it.
    function void take_byte(logic [7:0] b);
      sfr_result_t r;
      bit          framed;
      r      = '0;
      r.kind = KIND_NONE;
      framed = (mode == MODE_FRAME) || (mode == MODE_ESC);
      if (mode != MODE_ESC && b == chars.start_char) begin
        mode = MODE_FRAME;
        clear_frame();
      end else if (mode != MODE_ESC && b == chars.end_char) begin
        if (framed) begin
          if (ovf || kept < 9'd2) begin
            r.kind = KIND_BAD;
          end else if (sum == 8'd0) begin
            r.kind = KIND_GOOD;
            r.plen = 8'(kept - 9'd2);
          end else begin
            r.kind = KIND_CSUM;
          end
        end
        mode = MODE_HUNT;
        clear_frame();
      end else if (framed) begin
        sum = sum + b;
        if (mode == MODE_FRAME && b == chars.escape_char) begin
          mode = MODE_ESC;
        end else begin
          mode = MODE_FRAME;
          if (kept == 9'd0) begin
            r.kind = KIND_ID;
            r.data = b;
            kept   = 9'd1;
          end else if (kept < SFR_MAX_FRAME_BYTES) begin
            r.kind  = KIND_BODY;
            r.data  = b;
            r.index = 8'(kept - 9'd1);
            kept    = kept + 9'd1;
          end else begin
            ovf = 1'b1;
          end
        end
      end else begin
        mode = MODE_HUNT;
      end
      awaited_results.push_back(r);
    endfunction

    // Compares one result leaving the block with the oldest prediction.
    function void match_result(logic [2:0] kind, logic [7:0] data,
                               logic [7:0] idx, logic [7:0] plen);
      sfr_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: result_kind %0d", kind);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (data !== want.data) begin
        $error("data_byte: expected %0d, actual %0d", want.data, data);
        mismatches++;
      end
      if (idx !== want.index) begin
        $error("byte_index: expected %0d, actual %0d", want.index, idx);
        mismatches++;
      end
      if (plen !== want.plen) begin
        $error("payload_length: expected %0d, actual %0d", want.plen, plen);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  sfr_in_if  in_chan ();
  sfr_out_if out_chan ();

  stuffed_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  frame_decoder_model frames;
  logic [7:0]         line_q[$];
  logic [7:0]         line_sum;
  int                 sent_count;
  bit                 send_idle_on;
  bit                 recv_idle_on;
  bit                 hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("stuffed_frame_receiver verification failed");
    $finish;
  end

  // Result side: random stalls, idle-free stretches and one long hold-off.
  initial begin : result_sink
    int stall;
    int served;
    served = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (served % 40 == 0) recv_idle_on = ($urandom_range(0, 2) != 0);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = recv_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
      frames.match_result(out_chan.result_kind, out_chan.data_byte,
                          out_chan.byte_index, out_chan.payload_length);
      served++;
    end
  end

  function automatic bit is_special(logic [7:0] b);
    return b == frames.chars.start_char || b == frames.chars.end_char ||
           b == frames.chars.escape_char;
  endfunction

  // Random byte, with the special characters drawn often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return frames.chars.start_char;
      1:       return frames.chars.end_char;
      2:       return frames.chars.escape_char;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void begin_frame();
    line_q.push_back(frames.chars.start_char);
    line_sum = 8'd0;
  endfunction

  function automatic void close_frame();
    line_q.push_back(frames.chars.end_char);
  endfunction

  // One unstuffed byte; special characters are always escaped, others
  // sometimes. The escape itself counts in the checksum.
  function automatic void push_data(logic [7:0] b, int esc_pct);
    if (is_special(b) || $urandom_range(0, 99) < esc_pct) begin
      line_q.push_back(frames.chars.escape_char);
      line_sum = line_sum + frames.chars.escape_char;
    end
    line_q.push_back(b);
    line_sum = line_sum + b;
  endfunction

  // Checksum byte that brings the sum to zero, or to a random nonzero value.
  function automatic void push_checksum(bit good, int esc_pct);
    logic [7:0] target;
    target = 8'(8'd0 - line_sum);
    if (!good) target = 8'(target + $urandom_range(1, 255));
    if (is_special(target) || $urandom_range(0, 99) < esc_pct) begin
      line_q.push_back(frames.chars.escape_char);
      line_q.push_back(8'(target - frames.chars.escape_char));
    end else begin
      line_q.push_back(target);
    end
    line_sum = line_sum + target;
  endfunction

  function automatic void push_frame(int payload_len, int esc_pct, bit good, bit closed);
    begin_frame();
    for (int i = 0; i <= payload_len; i++) push_data(pick_byte(), esc_pct);
    push_checksum(good, esc_pct);
    if (closed) close_frame();
  endfunction

  // Offers one line byte after a random gap and waits for it to be taken.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (sent_count % 50 == 0) send_idle_on = ($urandom_range(0, 2) != 0);
    gap = send_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    frames.take_byte(b);
    sent_count++;
  endtask

  task automatic flush_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // Sender goes quiet until every predicted result has come out.
  task automatic pause_sender();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (frames.pending() != 0);
  endtask

  // Writes all three characters and the unused index; called while idle.
  task automatic load_chars(logic [7:0] s, logic [7:0] e, logic [7:0] x);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= s;
    @(posedge clk);
    frames.write_char(CFG_START, s);
    cfg_index <= CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    frames.write_char(CFG_END, e);
    cfg_index <= CFG_ESCAPE;
    cfg_wdata <= x;
    @(posedge clk);
    frames.write_char(CFG_ESCAPE, x);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= junk;
    @(posedge clk);
    frames.write_char(CFG_SPARE, junk);
    cfg_we <= 1'b0;
  endtask

  // Mix of mostly good frames with broken frames and noise in between.
  task automatic run_traffic(int n);
    int first;
    int pick;
    first = sent_count;
    while (sent_count - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_frame($urandom_range(0, 16), 10, 1'b1, 1'b1);
      end else if (pick < 77) begin
        push_frame($urandom_range(0, 16), 10, 1'b0, 1'b1);
      end else if (pick < 83) begin
        // Frame with fewer than two kept bytes.
        begin_frame();
        if ($urandom_range(0, 1) != 0) push_data(pick_byte(), 30);
        close_frame();
      end else if (pick < 89) begin
        // Frame cut off by whatever comes next.
        push_frame($urandom_range(0, 8), 10, 1'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // An end character hidden behind an escape, then the real end.
        begin_frame();
        push_data(pick_byte(), 0);
        line_q.push_back(frames.chars.escape_char);
        line_q.push_back(frames.chars.end_char);
        close_frame();
      end
      flush_line();
    end
  endtask

  initial begin : stimulus
    frames = new();
    sent_count      = 0;
    hold_req        = 1'b0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_START;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.rx_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset characters. Noise while hunting first.
    line_q.push_back(frames.chars.end_char);
    line_q.push_back(frames.chars.escape_char);
    line_q.push_back(8'hFF);
    // Empty frame and a frame with only an id.
    begin_frame();
    close_frame();
    begin_frame();
    push_data(8'h00, 0);
    close_frame();
    // Good frame carrying every special character as a literal.
    begin_frame();
    push_data(8'hFF, 0);
    push_data(frames.chars.start_char, 0);
    push_data(frames.chars.end_char, 0);
    push_data(frames.chars.escape_char, 0);
    push_checksum(1'b1, 0);
    close_frame();
    // Checksum error.
    begin_frame();
    push_data(8'h00, 0);
    push_data(8'h80, 0);
    push_checksum(1'b0, 0);
    close_frame();
    // A start inside a frame drops it and opens a fresh one.
    begin_frame();
    push_data(8'h11, 0);
    begin_frame();
    push_data(8'h22, 0);
    push_checksum(1'b1, 0);
    close_frame();
    flush_line();

    run_traffic(60);
    pause_sender();

    // Extremes of the character values, and the full and overflowing frames.
    load_chars(8'h00, 8'hFF, 8'h80);
    push_frame(SFR_MAX_FRAME_BYTES - 2, 0, 1'b1, 1'b1);
    flush_line();
    push_frame(SFR_MAX_FRAME_BYTES, 0, 1'b1, 1'b1);
    flush_line();
    run_traffic(60);
    pause_sender();

    load_chars(8'hFF, 8'h00, 8'h01);
    run_traffic(60);
    // Receiver holds off for a long stretch while bytes keep coming.
    hold_req = 1'b1;
    run_traffic(60);
    pause_sender();
    run_traffic(40);
    pause_sender();

    load_chars(8'h7E, 8'h7F, 8'h7D);
    run_traffic(60);
    pause_sender();

    // End and escape share a value, so no escape can be opened in a frame.
    load_chars(8'hC0, 8'hDB, 8'hDB);
    run_traffic(40);
    pause_sender();

    load_chars(8'($urandom_range(0, 84)), 8'($urandom_range(85, 169)),
               8'($urandom_range(170, 255)));
    run_traffic(40);

    // Wind down and let the last results out.
    in_chan.valid <= 1'b0;
    for (int w = 0; w < 5000 && frames.pending() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frames.pending() != 0) begin
      $error("%0d predicted results never arrived", frames.pending());
      frames.mismatches++;
    end
    if (frames.mismatches == 0) begin
      $display("stuffed_frame_receiver verification clean");
    end else begin
      $display("stuffed_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
